// ===== design/jccp_pkg.sv =====
// Shared constants, types and state codes of the joystick center calibration block.
`timescale 1ns / 1ps
package jccp_pkg;

   // Default sample width and calibration depth.
   localparam int SAMPLE_BITS_DEF     = 12;
   localparam int MAX_CAL_SAMPLES_DEF = 64;

   // Calibration depth register.
   localparam int            CFG_W     = 7;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd20;

   // Percent result width.
   localparam int PCT_W = 8;

   // Extra numerator bits: x100 needs 7, the ceiling bias needs 1.
   localparam int NUM_EXTRA = 8;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIFF,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== design/jccp_if.sv =====
// Channel interfaces: sample request, percent response and calibration depth write.
`timescale 1ns / 1ps
interface jccp_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] vert_sample;
   logic [SAMPLE_BITS-1:0] horz_sample;

   modport source (output valid, output vert_sample, output horz_sample, input ready);
   modport sink   (input valid, input vert_sample, input horz_sample, output ready);
endinterface

interface jccp_rsp_if;
   import jccp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [PCT_W-1:0]  vert_percent;
   logic signed [PCT_W-1:0]  horz_percent;

   modport source (output valid, output vert_percent, output horz_percent, input ready);
   modport sink   (input valid, input vert_percent, input horz_percent, output ready);
endinterface

interface jccp_csr_if;
   import jccp_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] calibration_samples;

   modport source (output valid, output calibration_samples, input ready);
   modport sink   (input valid, input calibration_samples, output ready);
endinterface

// ===== design/jccp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module jccp_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;

   logic [DEN_W:0]   trial;
   logic             ge;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_in;

   // Trial subtract of the shifted remainder
   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      ge     = (trial >= {1'b0, den});
      rem_in = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
   end

   // Iteration control and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
            rem_ff  <= '0;
            quo_ff  <= num;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== design/joystick_center_calibrate_percent_unit.sv =====
// Top level: joystick center calibration and signed percent deflection.
// Calibration items are summed in the accept cycle; the block is ready again next cycle.
// A measurement item runs MUL, DIFF, START and DIV for the vertical axis, then again for the
// horizontal axis, then DONE; each divide uses the one restoring divider shared by both axes,
// one quotient bit per cycle over NUM_W = SAMPLE_BITS + clog2(MAX_CAL_SAMPLES+1) + 8 bits.
// One item at a time, ready again with response valid; a stalled response holds the next.
// Synchronous reset clears sums, count, depth register (20) and handshake state.
`timescale 1ns / 1ps
module joystick_center_calibrate_percent_unit #(
   parameter int SAMPLE_BITS     = jccp_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_CAL_SAMPLES = jccp_pkg::MAX_CAL_SAMPLES_DEF
) (
   input logic           clock,
   input logic           reset,
   jccp_req_if.sink      req_chan,
   jccp_rsp_if.source    rsp_chan,
   jccp_csr_if.sink      csr_chan
);
   import jccp_pkg::*;

   localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;
   localparam int NUM_W = SUM_W + NUM_EXTRA;
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]       cal_n_ff;
   logic [SUM_W-1:0]       vsum_ff, hsum_ff;
   logic [CNT_W-1:0]       taken_ff;
   logic [SAMPLE_BITS-1:0] v_ff, h_ff;
   logic                   axis_ff;
   logic [SUM_W-1:0]       prod_ff;
   logic                   pos_ff, zero_ff;
   logic [SUM_W-1:0]       diff_ff, den_ff;
   logic [PCT_W-1:0]       vres_ff, hres_ff;
   logic                   rsp_valid_ff;
   logic [PCT_W-1:0]       rsp_vert_ff, rsp_horz_ff;

   logic                   req_xfer, rsp_load;
   logic [CMP_W-1:0]       eff_n, cfg_ext;
   logic                   cal_mode;
   logic [SAMPLE_BITS-1:0] sel_sample;
   logic [SUM_W-1:0]       sel_sum, cfull;
   logic [NUM_W-1:0]       mag100, num_start;
   logic                   div_done;
   logic [NUM_W-1:0]       div_quo;
   logic [PCT_W-1:0]       q8, res;

   // Effective calibration depth, clamped to 1..MAX_CAL_SAMPLES
   always_comb begin
      cfg_ext = CMP_W'(cal_n_ff);
      if (cfg_ext == '0)
         eff_n = CMP_W'(1);
      else if (cfg_ext > CMP_W'(MAX_CAL_SAMPLES))
         eff_n = CMP_W'(MAX_CAL_SAMPLES);
      else
         eff_n = cfg_ext;
      cal_mode = (CMP_W'(taken_ff) < eff_n);
   end

   assign req_xfer   = req_chan.valid && req_chan.ready;
   assign sel_sample = axis_ff ? h_ff : v_ff;
   assign sel_sum    = axis_ff ? hsum_ff : vsum_ff;
   assign cfull      = (SUM_W'(taken_ff) << SAMPLE_BITS) - SUM_W'(taken_ff);

   // Numerator: |d|*100, plus R-1 for the ceiling on the negative side
   always_comb begin
      mag100    = (NUM_W'(diff_ff) << 6) + (NUM_W'(diff_ff) << 5) + (NUM_W'(diff_ff) << 2);
      num_start = pos_ff ? mag100 : mag100 + NUM_W'(den_ff) - NUM_W'(1);
   end

   // Quotient to signed percent
   always_comb begin
      q8 = div_quo[PCT_W-1:0];
      if (zero_ff)
         res = '0;
      else if (pos_ff)
         res = q8;
      else
         res = PCT_W'(0) - q8;
   end

   jccp_div #(
      .NUM_W (NUM_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_START),
      .num   (num_start),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Next state and handshake outputs
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && !cal_mode)
               state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done)
               state_in = axis_ff ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   // Calibration depth register
   always_ff @(posedge clock) begin
      if (reset)
         cal_n_ff <= CFG_RESET;
      else if (csr_chan.valid && csr_chan.ready)
         cal_n_ff <= csr_chan.calibration_samples;
   end

   // Calibration sums and count
   always_ff @(posedge clock) begin
      if (reset) begin
         vsum_ff  <= '0;
         hsum_ff  <= '0;
         taken_ff <= '0;
      end else if (state_ff == ST_IDLE && req_xfer && cal_mode) begin
         vsum_ff  <= vsum_ff + SUM_W'(req_chan.vert_sample);
         hsum_ff  <= hsum_ff + SUM_W'(req_chan.horz_sample);
         taken_ff <= taken_ff + 1'b1;
      end
   end

   // Per-axis datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               v_ff    <= req_chan.vert_sample;
               h_ff    <= req_chan.horz_sample;
               axis_ff <= 1'b0;
            end
            ST_MUL: begin
               prod_ff <= SUM_W'(taken_ff) * SUM_W'(sel_sample);
            end
            ST_DIFF: begin
               pos_ff  <= (prod_ff > sel_sum);
               zero_ff <= (prod_ff <= sel_sum) && (sel_sum == '0);
               diff_ff <= (prod_ff > sel_sum) ? prod_ff - sel_sum : sel_sum - prod_ff;
               den_ff  <= (prod_ff > sel_sum) ? cfull - sel_sum : sel_sum;
            end
            ST_DIV: begin
               if (div_done && !axis_ff) begin
                  vres_ff <= res;
                  axis_ff <= 1'b1;
               end else if (div_done) begin
                  hres_ff <= res;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Response output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_vert_ff <= vres_ff;
         rsp_horz_ff <= hres_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.vert_percent = rsp_vert_ff;
   assign rsp_chan.horz_percent = rsp_horz_ff;

endmodule

// ===== design/jccp_chk.sv =====
// Port-level checker for the joystick calibration unit, bound to the top level.
`timescale 1ns / 1ps
module jccp_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] rsp_vert,
   input logic signed [7:0] rsp_horz
);

   // A stalled response keeps valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_vert) && $stable(rsp_horz))
      else $error("response payload changed while stalled");

   // Percents stay within -100..100
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vert >= -8'sd100 && rsp_vert <= 8'sd100 &&
                    rsp_horz >= -8'sd100 && rsp_horz <= 8'sd100)
      else $error("percent out of range");

   // A new response only appears after a busy period
   a_busy_before_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while request side was ready");

   // No response directly after a request transfer
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response one cycle after request transfer");

endmodule

bind joystick_center_calibrate_percent_unit jccp_chk u_jccp_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_vert  (rsp_chan.vert_percent),
   .rsp_horz  (rsp_chan.horz_percent)
);

// ===== tb/tb_top.sv =====
// Testbench for the joystick center calibration block: checks calibration and percent results.
`timescale 1ns / 1ps
module tb_top;
   import jccp_pkg::*;

   localparam int FULL_CODE    = (1 << SAMPLE_BITS_DEF) - 1;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 325;

   typedef struct packed {
      logic signed [PCT_W-1:0] vert;
      logic signed [PCT_W-1:0] horz;
   } percent_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jccp_req_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) req_bus ();
   jccp_rsp_if                                  rsp_bus ();
   jccp_csr_if                                  csr_bus ();

   joystick_center_calibrate_percent_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state
   logic [CFG_W-1:0] cal_depth = CFG_RESET;
   int unsigned      vert_acc  = 0;
   int unsigned      horz_acc  = 0;
   int unsigned      pairs_summed = 0;
   percent_pair_type pending_percents[$];

   int idle_pct   = 0;
   int stall_pct  = 0;
   int error_count = 0;
   int cycle_count = 0;

   // Clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.vert_sample = '0;
      req_bus.horz_sample = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.calibration_samples = '0;
      rsp_bus.ready       = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);
   end

   // Effective calibration depth: register clamped to 1..MAX
   function automatic int unsigned depth_limit(logic [CFG_W-1:0] depth);
      if (depth < 1) return 1;
      if (depth > MAX_CAL_SAMPLES_DEF) return MAX_CAL_SAMPLES_DEF;
      return depth;
   endfunction

   // floor((cv-sum)*100/span) if cv>sum, else -ceil((sum-cv)*100/sum), 8-bit two's complement
   function automatic logic [PCT_W-1:0] deflection_pct(int unsigned code, int unsigned sum,
                                                       int unsigned count);
      longint unsigned cv;
      longint unsigned span;
      longint unsigned quot;
      logic [63:0]     neg;
      cv = longint'(count) * code;
      if (cv > sum) begin
         span = longint'(count) * FULL_CODE - sum;
         quot = ((cv - sum) * 100) / span;
         return quot[PCT_W-1:0];
      end
      // zero range: center and sample both at zero
      if (sum == 0) return '0;
      quot = ((longint'(sum) - cv) * 100 + sum - 1) / sum;
      neg  = 64'(0) - quot;
      return neg[PCT_W-1:0];
   endfunction

   // Update sums or queue the expected percents for one accepted pair
   task automatic absorb_sample(logic [11:0] vert, logic [11:0] horz);
      percent_pair_type pair;
      if (pairs_summed < depth_limit(cal_depth)) begin
         vert_acc += vert;
         horz_acc += horz;
         pairs_summed++;
      end else begin
         pair.vert = deflection_pct(vert, vert_acc, pairs_summed);
         pair.horz = deflection_pct(horz, horz_acc, pairs_summed);
         pending_percents.push_back(pair);
      end
   endtask

   // Send one sample pair; called and returns at a falling edge
   task automatic send_sample(logic [11:0] vert, logic [11:0] horz);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_bus.valid       = 1'b1;
      req_bus.vert_sample = vert;
      req_bus.horz_sample = horz;
      do @(posedge clock); while (!req_bus.ready);
      absorb_sample(vert, horz);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Wait for all responses plus the divider latency
   task automatic wait_drained();
      while (pending_percents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the calibration depth register
   task automatic write_depth(logic [CFG_W-1:0] depth);
      wait_drained();
      csr_bus.valid = 1'b1;
      csr_bus.calibration_samples = depth;
      do @(posedge clock); while (!csr_bus.ready);
      cal_depth = depth;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Random code biased toward the extremes and the middle
   function automatic logic [11:0] pick_code();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'(FULL_CODE);
         2: return 12'(1984 + $urandom_range(128));
         default: return 12'($urandom_range(FULL_CODE));
      endcase
   endfunction

   // Response checker
   always @(posedge clock) begin
      percent_pair_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_percents.size() == 0) begin
            $error("unexpected response transfer: vert %0d horz %0d",
                   rsp_bus.vert_percent, rsp_bus.horz_percent);
            error_count++;
         end else begin
            want = pending_percents.pop_front();
            if (rsp_bus.vert_percent !== want.vert) begin
               $error("vert_percent mismatch: expected %0d, actual %0d",
                      want.vert, rsp_bus.vert_percent);
               error_count++;
            end
            if (rsp_bus.horz_percent !== want.horz) begin
               $error("horz_percent mismatch: expected %0d, actual %0d",
                      want.horz, rsp_bus.horz_percent);
               error_count++;
            end
         end
      end
   end

   // Depth 0 acts as 1; calibrate on (0, full) so the vertical center is zero
   task automatic test_zero_center();
      write_depth(7'd0);
      send_sample(12'd0, 12'd4095);
      send_sample(12'd0, 12'd4095);      // 0/0 on vertical, exact center on horizontal
      send_sample(12'd4095, 12'd0);
      send_sample(12'd0, 12'd0);
      send_sample(12'd4095, 12'd4095);
      send_sample(12'd2048, 12'd2047);
      send_sample(12'd1, 12'd4094);
   endtask

   // Raising depth resumes summing; lowering it under the pairs taken leaves measuring on
   task automatic test_depth_change();
      write_depth(7'd5);
      send_sample(12'd4095, 12'd0);
      send_sample(12'd0, 12'd4095);
      send_sample(12'd1234, 12'd3000);
      send_sample(12'd4095, 12'd4095);
      send_sample(12'd4095, 12'd0);
      send_sample(12'd0, 12'd4095);
      send_sample(12'd2000, 12'd1500);
      write_depth(7'd2);
      send_sample(12'd1000, 12'd3000);
      send_sample(12'd3500, 12'd100);
      write_depth(7'd1);
      send_sample(12'd2048, 12'd2048);
   endtask

   // One random phase at a given depth and idle mix
   task automatic test_random_phase(logic [CFG_W-1:0] depth, int sender_idle, int recv_stall);
      write_depth(depth);
      idle_pct  = sender_idle;
      stall_pct = recv_stall;
      repeat (PHASE_ITEMS) send_sample(pick_code(), pick_code());
      wait_drained();
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_zero_center();
      test_depth_change();
      test_random_phase(7'd30, 0, 0);
      test_random_phase(7'd64, 64, 0);
      test_random_phase(7'd127, 0, 64);
      test_random_phase(7'($urandom_range(127)), 24, 24);

      wait_drained();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/jccp_pkg.sv
design/jccp_if.sv
design/jccp_div.sv
design/joystick_center_calibrate_percent_unit.sv
design/jccp_chk.sv
tb/tb_top.sv
